[sv/spc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Types and constants shared by the stepper position controller.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int QUEUE_DEPTH   = 8;
    localparam int POSITION_BITS = 16;
    localparam int ARG_BITS      = 16;
    localparam int DELAY_BITS    = ARG_BITS + 1;
    localparam int QIDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ARG_BITS-1:0] STEP_DELAY_RESET = ARG_BITS'(50);

    // Word kinds.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    // Command codes.
    localparam logic [1:0] OP_MOVE_TO   = 2'd0;
    localparam logic [1:0] OP_HOME      = 2'd1;
    localparam logic [1:0] OP_PAUSE     = 2'd2;
    localparam logic [1:0] OP_SET_DELAY = 2'd3;

    // Published status codes.
    localparam logic [1:0] STATUS_CALIB   = 2'd0;
    localparam logic [1:0] STATUS_IDLE    = 2'd1;
    localparam logic [1:0] STATUS_MOVING  = 2'd2;
    localparam logic [1:0] STATUS_WAITING = 2'd3;

    typedef enum logic [2:0] {
        MODE_CALIB  = 3'b001,
        MODE_IDLE   = 3'b010,
        MODE_MOVING = 3'b100
    } t_mode;

    typedef struct packed {
        logic                kind;
        logic                detector_active;
        logic [1:0]          command_type;
        logic [ARG_BITS-1:0] command_argument;
    } t_in_word;

    typedef struct packed {
        logic                     step_right;
        logic                     step_left;
        logic [1:0]               status_mode;
        logic [POSITION_BITS-1:0] status_position;
        logic                     command_dropped;
    } t_out_word;

    typedef struct packed {
        logic [1:0]          command_type;
        logic [ARG_BITS-1:0] command_argument;
    } t_cmd_entry;

endpackage

[sv/stepper_position_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_position_controller
// Stepper position controller with homing, command queue and tick-paced
// iterations.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Word
//  --------+-----------+---------------------------+----------------------
//  in      | input     | i_in_valid / o_in_stall   | t_in_word  (tick or command)
//  out     | output    | o_out_valid / i_out_stall | t_out_word (one per input)
//  cfg     | input     | i_cfg_we                  | i_cfg_data (home offset)
//
// One word can be accepted in every clock cycle while the input side is not
// stalled. An accepted word lands in the input register, the controller
// logic works on it once the result register is free, and its result word
// is then loaded into the result register.
// Reset is synchronous and active low; it puts the controller in
// calibration with an empty queue, without any clearing pass.
// A stalled output holds its word, and the input register still takes one
// more word before the input side is stalled. Once both registers are full,
// the input stall follows the output stall within the same cycle.
//
module stepper_position_controller
    import spc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_word                 i_in_word,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_word                o_out_word,
    input  logic                     i_cfg_we,
    input  logic [POSITION_BITS-1:0] i_cfg_data
);

    // Reload value of the delay counter: ticks minus one, floored at zero.
    function automatic logic [DELAY_BITS-1:0] reload_of(input logic [DELAY_BITS-1:0] ticks);
        reload_of = (ticks == '0) ? '0 : ticks - 1'b1;
    endfunction

    // Input register and result register.
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    // Controller state.
    logic [POSITION_BITS-1:0] r_home_offset;
    t_mode                    r_mode,  n_mode;
    logic [POSITION_BITS-1:0] r_position, n_position;
    logic [POSITION_BITS-1:0] r_target, n_target;
    logic [ARG_BITS-1:0]      r_step_delay, n_step_delay;
    logic [DELAY_BITS-1:0]    r_delay_left, n_delay_left;
    logic [1:0]               r_shown_mode, n_shown_mode;
    logic [POSITION_BITS-1:0] r_shown_position, n_shown_position;
    logic [QIDX_W-1:0]        r_head, n_head;
    logic [QCNT_W-1:0]        r_count, n_count;

    // Command queue storage. Entries are read only after being written.
    t_cmd_entry r_store [QUEUE_DEPTH];

    logic       w_out_free;
    logic       w_load;
    logic       w_work;
    logic       w_store_we;
    logic [QIDX_W-1:0]  w_tail;
    logic [QCNT_W:0]    w_tail_sum;
    t_cmd_entry w_entry;
    t_out_word  n_out;

    // The result register frees up when empty or when its word is taken.
    assign w_out_free = !r_out_valid || !i_out_stall;
    // The input register loads when empty or when its word moves on.
    assign w_load     = !r_in_valid || w_out_free;
    assign w_work     = r_in_valid && w_out_free;
    assign o_in_stall = !w_load;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Write slot of the queue: head plus fill count, wrapped at the depth.
    assign w_tail_sum = (QCNT_W + 1)'(r_head) + (QCNT_W + 1)'(r_count);
    always_comb begin
        if (w_tail_sum >= (QCNT_W + 1)'(QUEUE_DEPTH)) begin
            w_tail = QIDX_W'(w_tail_sum - (QCNT_W + 1)'(QUEUE_DEPTH));
        end else begin
            w_tail = QIDX_W'(w_tail_sum);
        end
    end

    assign w_entry = r_store[r_head];

    always_comb begin
        n_mode           = r_mode;
        n_position       = r_position;
        n_target         = r_target;
        n_step_delay     = r_step_delay;
        n_delay_left     = r_delay_left;
        n_shown_mode     = r_shown_mode;
        n_shown_position = r_shown_position;
        n_head           = r_head;
        n_count          = r_count;
        w_store_we       = 1'b0;
        n_out            = '0;

        if (w_work) begin
            if (r_in.kind == KIND_COMMAND) begin
                // A command goes into the queue unless the queue is full.
                if (r_count == QCNT_W'(QUEUE_DEPTH)) begin
                    n_out.command_dropped = 1'b1;
                end else begin
                    w_store_we = 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end else if (r_delay_left != '0) begin
                n_delay_left = r_delay_left - 1'b1;
            end else begin
                // One controller iteration: publish status, then act.
                n_delay_left     = reload_of(DELAY_BITS'(r_step_delay));
                n_shown_position = r_position;
                case (r_mode)
                    MODE_CALIB: begin
                        n_shown_mode = STATUS_CALIB;
                        if (r_in.detector_active) begin
                            n_mode     = MODE_IDLE;
                            n_position = r_home_offset;
                            n_target   = '0;
                        end else begin
                            n_out.step_left = 1'b1;
                        end
                    end
                    MODE_IDLE: begin
                        n_shown_mode = STATUS_IDLE;
                        if (r_count == '0) begin
                            // Nothing queued: try again on the next tick.
                            n_delay_left = '0;
                        end else begin
                            n_head  = (r_head == QIDX_W'(QUEUE_DEPTH - 1)) ?
                                      '0 : r_head + 1'b1;
                            n_count = r_count - 1'b1;
                            case (w_entry.command_type)
                                OP_MOVE_TO: begin
                                    n_target = POSITION_BITS'(w_entry.command_argument);
                                    n_mode   = MODE_MOVING;
                                end
                                OP_HOME: begin
                                    n_mode = MODE_CALIB;
                                end
                                OP_SET_DELAY: begin
                                    n_step_delay = w_entry.command_argument;
                                    n_delay_left =
                                        reload_of(DELAY_BITS'(w_entry.command_argument));
                                end
                                default: begin
                                    // Wait: shows waiting for argument plus delay ticks.
                                    n_shown_mode = STATUS_WAITING;
                                    n_delay_left = reload_of(
                                        DELAY_BITS'(w_entry.command_argument) +
                                        DELAY_BITS'(r_step_delay));
                                end
                            endcase
                        end
                    end
                    MODE_MOVING: begin
                        n_shown_mode = STATUS_MOVING;
                        if (r_position < r_target) begin
                            n_out.step_right = 1'b1;
                            n_position       = r_position + 1'b1;
                        end else if (r_position > r_target) begin
                            n_out.step_left = 1'b1;
                            n_position      = r_position - 1'b1;
                        end else begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                    end
                endcase
            end
            n_out.status_mode     = n_shown_mode;
            n_out.status_position = n_shown_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_home_offset    <= '0;
            r_mode           <= MODE_CALIB;
            r_position       <= '0;
            r_target         <= '0;
            r_step_delay     <= STEP_DELAY_RESET;
            r_delay_left     <= '0;
            r_shown_mode     <= STATUS_IDLE;
            r_shown_position <= '0;
            r_head           <= '0;
            r_count          <= '0;
        end else begin
            if (w_load) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_we) begin
                r_home_offset <= i_cfg_data;
            end
            r_mode           <= n_mode;
            r_position       <= n_position;
            r_target         <= n_target;
            r_step_delay     <= n_step_delay;
            r_delay_left     <= n_delay_left;
            r_shown_mode     <= n_shown_mode;
            r_shown_position <= n_shown_position;
            r_head           <= n_head;
            r_count          <= n_count;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in <= i_in_word;
        end
        if (w_work) begin
            r_out <= n_out;
        end
        if (w_store_we) begin
            r_store[w_tail] <= '{command_type:     r_in.command_type,
                                 command_argument: r_in.command_argument};
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stepper position controller. Directed tests
// cover homing, stepping in both directions, queue overflow and long
// delays. Random traffic follows under several home offsets. A predictor
// in the bench computes the expected result word for every accepted input
// word, and a checker compares each output word field by field.
// ----------------------------------------------------------------------------
module tb;
    import spc_pkg::*;

    // Cycles with no handshake on either channel before the run is abandoned.
    localparam int STALL_LIMIT  = 2000;
    // Each word passes through the input register and the result register.
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 200;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;
    logic      cfg_we;
    logic [POSITION_BITS-1:0] cfg_data;

    int unsigned sender_idle_pct   = 30;
    int unsigned receiver_idle_pct = 30;
    int          hold_cycles       = 0;
    int          fail_count        = 0;
    int          quiet_cycles      = 0;

    // Predictor state, mirroring the controller after reset.
    t_mode                    ctl_mode       = MODE_CALIB;
    logic [POSITION_BITS-1:0] pos            = '0;
    logic [POSITION_BITS-1:0] tgt            = '0;
    logic [ARG_BITS-1:0]      speed_ticks    = STEP_DELAY_RESET;
    logic [DELAY_BITS-1:0]    tick_countdown = '0;
    logic [1:0]               shown_status   = STATUS_IDLE;
    logic [POSITION_BITS-1:0] shown_pos      = '0;
    logic [POSITION_BITS-1:0] home_offset    = '0;
    t_cmd_entry               cmd_fifo[$];
    t_out_word                expected_status[$];

    stepper_position_controller i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Ticks needed before the next iteration, given a delay in ticks.
    function automatic logic [DELAY_BITS-1:0] reload_ticks(input logic [DELAY_BITS-1:0] ticks);
        return (ticks == '0) ? '0 : ticks - 1'b1;
    endfunction

    // Advances the predictor by one accepted input word and returns the
    // result word the block must produce for it.
    function automatic t_out_word predict_status(input t_in_word w);
        t_out_word             res;
        t_cmd_entry            entry;
        logic [DELAY_BITS-1:0] next_wait;
        res = '0;
        if (w.kind == KIND_COMMAND) begin
            if (cmd_fifo.size() >= QUEUE_DEPTH) begin
                res.command_dropped = 1'b1;
            end else begin
                entry.command_type     = w.command_type;
                entry.command_argument = w.command_argument;
                cmd_fifo.push_back(entry);
            end
        end else if (tick_countdown != '0) begin
            tick_countdown = tick_countdown - 1'b1;
        end else begin
            // One controller iteration: publish first, then act.
            next_wait = reload_ticks(DELAY_BITS'(speed_ticks));
            case (ctl_mode)
                MODE_CALIB:  shown_status = STATUS_CALIB;
                MODE_IDLE:   shown_status = STATUS_IDLE;
                default:     shown_status = STATUS_MOVING;
            endcase
            shown_pos = pos;
            case (ctl_mode)
                MODE_CALIB: begin
                    if (w.detector_active) begin
                        ctl_mode = MODE_IDLE;
                        pos      = home_offset;
                        tgt      = '0;
                    end else begin
                        res.step_left = 1'b1;
                    end
                end
                MODE_IDLE: begin
                    // An empty queue leaves the countdown at zero, so the
                    // very next tick looks at the queue again.
                    if (cmd_fifo.size() == 0) begin
                        next_wait = '0;
                    end else begin
                        entry = cmd_fifo.pop_front();
                        case (entry.command_type)
                            OP_MOVE_TO: begin
                                tgt      = POSITION_BITS'(entry.command_argument);
                                ctl_mode = MODE_MOVING;
                            end
                            OP_HOME: ctl_mode = MODE_CALIB;
                            OP_SET_DELAY: begin
                                speed_ticks = entry.command_argument;
                                next_wait   = reload_ticks(DELAY_BITS'(speed_ticks));
                            end
                            default: begin
                                // Wait command.
                                shown_status = STATUS_WAITING;
                                next_wait    = reload_ticks(DELAY_BITS'(entry.command_argument)
                                                            + DELAY_BITS'(speed_ticks));
                            end
                        endcase
                    end
                end
                default: begin
                    if (pos < tgt) begin
                        res.step_right = 1'b1;
                        pos            = pos + 1'b1;
                    end else if (pos > tgt) begin
                        res.step_left = 1'b1;
                        pos           = pos - 1'b1;
                    end else begin
                        ctl_mode = MODE_IDLE;
                    end
                end
            endcase
            tick_countdown = next_wait;
        end
        res.status_mode     = shown_status;
        res.status_position = shown_pos;
        return res;
    endfunction

    // The fields a word does not use are filled at random.
    function automatic t_in_word tick_word(input logic detector);
        t_in_word w;
        w                  = '0;
        w.kind             = KIND_TICK;
        w.detector_active  = detector;
        w.command_type     = 2'($urandom);
        w.command_argument = ARG_BITS'($urandom);
        return w;
    endfunction

    function automatic t_in_word command_word(input logic [1:0] code,
                                              input logic [ARG_BITS-1:0] arg);
        t_in_word w;
        w                  = '0;
        w.kind             = KIND_COMMAND;
        w.detector_active  = 1'($urandom);
        w.command_type     = code;
        w.command_argument = arg;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expd,
                                        input logic [31:0] act);
        if (expd != act) begin
            $error("%s expected %0h actual %0h", name, expd, act);
            fail_count++;
        end
    endfunction

    // Offers one word, possibly after a random gap, and holds it until the
    // block takes it. Returns right after the accepting edge.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = ($urandom_range(0, 99) < sender_idle_pct) ? int'($urandom_range(1, 4)) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_status.push_back(predict_status(w));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // The register is only written once the block has gone quiet.
    task automatic write_home_offset(input logic [POSITION_BITS-1:0] value);
        stop_sending();
        while (expected_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        home_offset = value;
    endtask

    // Counts down any pending delay, then sends the tick that iterates.
    task automatic next_iteration(input logic detector);
        while (tick_countdown != '0) send_word(tick_word(1'($urandom)));
        send_word(tick_word(detector));
    endtask

    // Ticks until the queue is empty and the controller sits idle.
    task automatic settle_controller();
        while (cmd_fifo.size() != 0 || ctl_mode != MODE_IDLE) send_word(tick_word(1'b1));
    endtask

    // Out of reset the block calibrates with the slow default delay.
    task automatic test_homing();
        write_home_offset({POSITION_BITS{1'b1}});
        // These commands show the reset status and wait in the queue.
        send_word(command_word(OP_SET_DELAY, 16'h0000));
        send_word(command_word(OP_MOVE_TO, 16'hFFFF));
        next_iteration(1'b0);       // no detector: step left, position held
        next_iteration(1'b1);       // homed at the offset
        next_iteration(1'b0);       // speed 0 acts as a one-tick delay
        next_iteration(1'b0);       // goto the current position
        next_iteration(1'b0);       // already there, back to idle
        next_iteration(1'b0);       // idle with nothing queued
        next_iteration(1'b0);
    endtask

    task automatic test_stepping();
        send_word(command_word(OP_MOVE_TO, 16'hFFFD));
        send_word(command_word(OP_MOVE_TO, 16'hFFFF));
        settle_controller();
        send_word(command_word(OP_HOME, 16'h0000));
        next_iteration(1'b0);
        next_iteration(1'b0);
        next_iteration(1'b1);
        write_home_offset('0);
        send_word(command_word(OP_HOME, 16'hFFFF));
        next_iteration(1'b1);
        next_iteration(1'b1);
        send_word(command_word(OP_MOVE_TO, 16'h0000));
        send_word(command_word(OP_MOVE_TO, 16'h0002));
        send_word(command_word(OP_MOVE_TO, 16'h0000));
        settle_controller();
    endtask

    // Fills the queue, then two more commands must be dropped.
    task automatic test_queue_overflow();
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i % 2 == 0)
                send_word(command_word(OP_PAUSE, ARG_BITS'(i)));
            else
                send_word(command_word(OP_SET_DELAY, '0));
        end
        send_word(command_word(OP_PAUSE, 16'hFFFF));
        send_word(command_word(2'($urandom), 16'($urandom)));
        settle_controller();
    endtask

    // Long waits and step delays. Neither side idles here, which also
    // gives the long stretch without gaps.
    task automatic test_long_delays();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_word(command_word(OP_SET_DELAY, 16'h0002));
        send_word(command_word(OP_PAUSE, 16'h0064));
        send_word(command_word(OP_SET_DELAY, 16'h0032));
        send_word(command_word(OP_SET_DELAY, 16'h0000));
        settle_controller();
        sender_idle_pct   = 30;
        receiver_idle_pct = 30;
    endtask

    // Mostly well-formed command streams with targets kept near the
    // position the controller will have reached, so moves stay short.
    // Commands offered to a full queue are fully random.
    task automatic test_random_traffic(input int count,
                                       input logic [POSITION_BITS-1:0] offset,
                                       input bit hold_receiver);
        int planned_pos;
        int pick;
        settle_controller();
        write_home_offset(offset);
        planned_pos = int'(pos);
        for (int n = 0; n < count; n++) begin
            if (hold_receiver && n == 1) hold_cycles = HOLD_CYCLES;
            if ($urandom_range(0, 99) < 60) begin
                send_word(tick_word($urandom_range(0, 3) == 0));
            end else if (cmd_fifo.size() >= QUEUE_DEPTH) begin
                send_word(command_word(2'($urandom), 16'($urandom)));
            end else begin
                pick = int'($urandom_range(0, 99));
                if (pick < 45) begin
                    planned_pos = planned_pos + int'($urandom_range(0, 32)) - 16;
                    if (planned_pos < 0) planned_pos = 0;
                    if (planned_pos > 16'hFFFF) planned_pos = 16'hFFFF;
                    send_word(command_word(OP_MOVE_TO, ARG_BITS'(planned_pos)));
                end else if (pick < 60) begin
                    planned_pos = int'(home_offset);
                    send_word(command_word(OP_HOME, 16'($urandom)));
                end else if (pick < 80) begin
                    send_word(command_word(OP_PAUSE, ARG_BITS'($urandom_range(0, 10))));
                end else begin
                    send_word(command_word(OP_SET_DELAY, ARG_BITS'($urandom_range(0, 4))));
                end
            end
        end
        settle_controller();
    endtask

    // Output side: random stalls, or a long hold when one is requested.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (hold_cycles - 1) @(negedge clk);
                hold_cycles = 0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
            end
        end
    end

    // Every accepted output word is compared with the oldest prediction.
    always @(posedge clk) begin
        t_out_word expd;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_status.size() == 0) begin
                $error("output word with no prediction pending: %0h", out_word);
                fail_count++;
            end else begin
                expd = expected_status.pop_front();
                check_field("step_right", 32'(expd.step_right), 32'(out_word.step_right));
                check_field("step_left", 32'(expd.step_left), 32'(out_word.step_left));
                check_field("status_mode", 32'(expd.status_mode),
                            32'(out_word.status_mode));
                check_field("status_position", 32'(expd.status_position),
                            32'(out_word.status_position));
                check_field("command_dropped", 32'(expd.command_dropped),
                            32'(out_word.command_dropped));
            end
        end
    end

    // Watchdog: too long without any handshake means the block has hung.
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_homing();
        test_stepping();
        test_queue_overflow();
        test_long_delays();
        test_random_traffic(300, 16'($urandom), 1'b1);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_traffic(300, '0, 1'b0);
        sender_idle_pct   = 30;
        receiver_idle_pct = 30;
        test_random_traffic(300, {POSITION_BITS{1'b1}}, 1'b0);

        stop_sending();
        while (expected_status.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
